// ===== sv/vba3d_pkg.sv =====
// vba3d_pkg: constants, register codes and types of the voxel block averager
// no dependencies, imported by voxel_block_average_3d_core

package vba3d_pkg;

  // defaults of the top-level parameters
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_BIN_DEF   = 16;

  // field and register widths
  localparam int SAMPLE_BITS = 32;
  localparam int AVG_W       = 32;
  localparam int BIN_W       = 5;
  localparam int RECIP_W     = 25;
  localparam int POS_W       = 13;
  localparam int SLICE_W     = 16;
  localparam int DIV_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 25;

  // reciprocal is Q1.24, multiplied in two halves split at this bit
  localparam int FRAC_BITS   = 24;
  localparam int RECIP_SPLIT = 12;

  // result queue
  localparam int OUT_DEPTH = 8;

  localparam logic signed [AVG_W-1:0] AVG_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [AVG_W-1:0] AVG_MIN = 32'sh8000_0000;

  // register reset values
  localparam logic [BIN_W-1:0]   BIN_RST    = 5'd1;
  localparam logic [RECIP_W-1:0] RECIP_RST  = 25'h100_0000;
  localparam logic [POS_W-1:0]   WIDTH_RST  = 13'd4096;
  localparam logic [POS_W-1:0]   HEIGHT_RST = 13'd4096;
  localparam logic [SLICE_W-1:0] DEPTH_RST  = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_FACTOR = 3'd0,
    CFG_RECIP_CUBE = 3'd1,
    CFG_VOL_WIDTH  = 3'd2,
    CFG_VOL_HEIGHT = 3'd3,
    CFG_VOL_DEPTH  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_RUN
  } div_state_e;

  // quantities recomputed by the serial divider, in order
  typedef enum logic [2:0] {
    JOB_WIDTH,
    JOB_HEIGHT,
    JOB_DEPTH,
    JOB_COL,
    JOB_ROW,
    JOB_SLICE
  } div_job_e;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    slice_end;
    logic signed [AVG_W-1:0] slice_min;
    logic signed [AVG_W-1:0] slice_max;
  } out_entry_t;

endpackage

// ===== sv/voxel_block_average_3d_core.sv =====
// voxel_block_average_3d_core: a sample request reaches the average request through
// the line memory stage, the sum, product and average registers and the result queue.
// throughput one sample per cycle while in_stall_o is low; the line of block sums is
// one memory with a registered read, read-modify-written once per block run with
// write forwarding. after reset and after every register write the input stalls
// while a one-bit-per-cycle divider rebuilds block counts and block positions.
// reset is asynchronous active low; the line memory is not cleared. depends on vba3d_pkg

module voxel_block_average_3d_core
  import vba3d_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_BIN   = MAX_BIN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [AVG_W-1:0]       average_o,
  output logic                          slice_end_o,
  output logic signed [AVG_W-1:0]       slice_min_o,
  output logic signed [AVG_W-1:0]       slice_max_o
);

  localparam int ADDR_W   = $clog2(MAX_WIDTH);
  localparam int BIN_TOP  = (MAX_BIN < (2 ** BIN_W) - 1) ? MAX_BIN : (2 ** BIN_W) - 1;
  localparam int GROW     = $clog2(BIN_TOP);
  localparam int RUN_W    = SAMPLE_BITS + GROW;
  localparam int SUM_W    = SAMPLE_BITS + 3 * GROW;
  localparam int RH_W     = RECIP_W - RECIP_SPLIT;
  localparam int PH_W     = SUM_W + RH_W + 1;
  localparam int PL_W     = SUM_W + RECIP_SPLIT + 1;
  localparam int SH       = FRAC_BITS - RECIP_SPLIT;
  localparam int STEP_W   = $clog2(DIV_W);
  localparam int CNT_W    = $clog2(OUT_DEPTH + 1);
  localparam int PTR_W    = $clog2(OUT_DEPTH);

  // configuration registers
  logic [BIN_W-1:0]   bin_q;
  logic [RECIP_W-1:0] recip_q;
  logic [POS_W-1:0]   width_q, height_q;
  logic [SLICE_W-1:0] depth_q;

  logic [BIN_W-1:0]   b_eff, bm1;
  logic [POS_W-1:0]   w_eff, h_eff;
  logic [SLICE_W-1:0] d_eff;

  // positions and their block coordinates
  logic [POS_W-1:0]   col_q, col_d, row_q, row_d;
  logic [SLICE_W-1:0] slice_q, slice_d;
  logic [BIN_W-1:0]   rem_x_q, rem_x_d, rem_y_q, rem_y_d, rem_z_q, rem_z_d;
  logic [POS_W-1:0]   quo_x_q, quo_x_d, quo_y_q, quo_y_d;
  logic [POS_W-1:0]   onx_q, onx_d, ony_q, ony_d;
  logic [POS_W-1:0]   lim_x_q, lim_x_d, lim_y_q, lim_y_d;
  logic [SLICE_W-1:0] lim_z_q, lim_z_d;

  // serial divider
  div_state_e         div_state_q, div_state_d;
  div_job_e           job_q, job_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [BIN_W-1:0]   acc_q, acc_d;
  logic [DIV_W-1:0]   dq_q, dq_d;
  logic [DIV_W-1:0]   dividend;
  logic [BIN_W:0]     trial, trial_diff;
  logic               trial_ge;
  logic               div_done;
  logic               busy;

  // request side
  logic               accept;
  logic               in_range, run_end, first_blk, emit, last_blk;
  logic               col_last, row_last, slice_last;
  logic signed [RUN_W-1:0] run_sum_q, run_total;
  logic [ADDR_W-1:0]  rd_addr;

  // pipeline
  logic               v1_q, e1_q, f1_q, l1_q;
  logic [ADDR_W-1:0]  addr1_q;
  logic signed [RUN_W-1:0] run1_q;
  logic signed [SUM_W-1:0] rdata_q, base, blk_sum;
  logic               wr_v_q;
  logic [ADDR_W-1:0]  wr_addr_q;
  logic signed [SUM_W-1:0] wr_data_q;
  logic signed [SUM_W-1:0] line_mem [MAX_WIDTH];

  logic               v2_q, l2_q;
  logic signed [SUM_W-1:0] sum2_q;
  logic [RH_W-1:0]        rh;
  logic [RECIP_SPLIT-1:0] rl;
  logic signed [PH_W-1:0] ph_d, ph3_q, t_sum, q_full;
  logic signed [PL_W-1:0] pl_d, pl3_q;
  logic               v3_q, l3_q;
  logic               q_fits;
  logic signed [AVG_W-1:0] avg_d, avg4_q;
  logic               v4_q, l4_q;

  logic signed [AVG_W-1:0] run_min_q, run_max_q, new_min, new_max;

  // result queue
  out_entry_t         fifo_q [OUT_DEPTH];
  out_entry_t         push_entry, head;
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q, inflight;
  logic               push, pop;

  // ---------------------------------------------------------------- config

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q    <= BIN_RST;
      recip_q  <= RECIP_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      depth_q  <= DEPTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BIN_FACTOR: bin_q    <= cfg_wdata_i[BIN_W-1:0];
        CFG_RECIP_CUBE: recip_q  <= cfg_wdata_i[RECIP_W-1:0];
        CFG_VOL_WIDTH:  width_q  <= cfg_wdata_i[POS_W-1:0];
        CFG_VOL_HEIGHT: height_q <= cfg_wdata_i[POS_W-1:0];
        CFG_VOL_DEPTH:  depth_q  <= cfg_wdata_i[SLICE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bin_q == '0) begin
      b_eff = BIN_W'(1);
    end else if (int'(bin_q) > MAX_BIN) begin
      b_eff = BIN_W'(MAX_BIN);
    end else begin
      b_eff = bin_q;
    end
    bm1 = BIN_W'(b_eff - 1'b1);

    if (width_q == '0) begin
      w_eff = POS_W'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = POS_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end

    if (height_q == '0) begin
      h_eff = POS_W'(1);
    end else if (int'(height_q) > MAX_WIDTH) begin
      h_eff = POS_W'(MAX_WIDTH);
    end else begin
      h_eff = height_q;
    end

    d_eff = (depth_q == '0) ? SLICE_W'(1) : depth_q;
  end

  // ---------------------------------------------------------------- divider

  assign busy = (div_state_q != DIV_IDLE);

  always_comb begin
    case (job_q)
      JOB_WIDTH:  dividend = DIV_W'(w_eff);
      JOB_HEIGHT: dividend = DIV_W'(h_eff);
      JOB_DEPTH:  dividend = DIV_W'(d_eff);
      JOB_COL:    dividend = DIV_W'(col_q);
      JOB_ROW:    dividend = DIV_W'(row_q);
      JOB_SLICE:  dividend = DIV_W'(slice_q);
      default:    dividend = '0;
    endcase
  end

  // restoring division, one quotient bit per cycle
  assign trial      = {acc_q, dq_q[DIV_W-1]};
  assign trial_ge   = (trial >= {1'b0, b_eff});
  assign trial_diff = trial - {1'b0, b_eff};

  always_comb begin
    div_state_d = div_state_q;
    job_d       = job_q;
    step_d      = step_q;
    acc_d       = acc_q;
    dq_d        = dq_q;
    div_done    = 1'b0;
    case (div_state_q)
      DIV_IDLE: ;
      DIV_LOAD: begin
        acc_d       = '0;
        dq_d        = dividend;
        step_d      = '0;
        div_state_d = DIV_RUN;
      end
      DIV_RUN: begin
        acc_d  = trial_ge ? trial_diff[BIN_W-1:0] : trial[BIN_W-1:0];
        dq_d   = {dq_q[DIV_W-2:0], trial_ge};
        step_d = STEP_W'(step_q + 1'b1);
        if (step_q == STEP_W'(DIV_W - 1)) begin
          div_done = 1'b1;
          if (job_q == JOB_SLICE) begin
            div_state_d = DIV_IDLE;
          end else begin
            job_d       = div_job_e'(3'(job_q + 3'd1));
            div_state_d = DIV_LOAD;
          end
        end
      end
      default: div_state_d = DIV_LOAD;
    endcase
    // any register write restarts the whole pass
    if (cfg_we_i) begin
      div_state_d = DIV_LOAD;
      job_d       = JOB_WIDTH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DIV_LOAD;
      job_q       <= JOB_WIDTH;
      step_q      <= '0;
      acc_q       <= '0;
      dq_q        <= '0;
    end else begin
      div_state_q <= div_state_d;
      job_q       <= job_d;
      step_q      <= step_d;
      acc_q       <= acc_d;
      dq_q        <= dq_d;
    end
  end

  // ---------------------------------------------------------------- positions

  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (col_q < lim_x_q) && (row_q < lim_y_q) && (slice_q < lim_z_q);
  assign run_end    = (rem_x_q == bm1);
  assign first_blk  = (rem_y_q == '0) && (rem_z_q == '0);
  assign emit       = (rem_y_q == bm1) && (rem_z_q == bm1);
  assign last_blk   = (({1'b0, quo_x_q} + 1'b1) == {1'b0, onx_q}) &&
                      (({1'b0, quo_y_q} + 1'b1) == {1'b0, ony_q});
  assign col_last   = (({1'b0, col_q} + 1'b1) >= {1'b0, w_eff});
  assign row_last   = (({1'b0, row_q} + 1'b1) >= {1'b0, h_eff});
  assign slice_last = (({1'b0, slice_q} + 1'b1) >= {1'b0, d_eff});
  assign run_total  = run_sum_q + RUN_W'(sample_i);
  assign rd_addr    = ADDR_W'(quo_x_q);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    slice_d = slice_q;
    rem_x_d = rem_x_q;
    rem_y_d = rem_y_q;
    rem_z_d = rem_z_q;
    quo_x_d = quo_x_q;
    quo_y_d = quo_y_q;
    onx_d   = onx_q;
    ony_d   = ony_q;
    lim_x_d = lim_x_q;
    lim_y_d = lim_y_q;
    lim_z_d = lim_z_q;
    if (div_done) begin
      // dq_d holds the quotient and acc_d the remainder
      case (job_q)
        JOB_WIDTH: begin
          onx_d   = POS_W'(dq_d);
          lim_x_d = POS_W'(dividend - DIV_W'(acc_d));
        end
        JOB_HEIGHT: begin
          ony_d   = POS_W'(dq_d);
          lim_y_d = POS_W'(dividend - DIV_W'(acc_d));
        end
        JOB_DEPTH: lim_z_d = SLICE_W'(dividend - DIV_W'(acc_d));
        JOB_COL: begin
          quo_x_d = POS_W'(dq_d);
          rem_x_d = acc_d;
        end
        JOB_ROW: begin
          quo_y_d = POS_W'(dq_d);
          rem_y_d = acc_d;
        end
        JOB_SLICE: rem_z_d = acc_d;
        default: ;
      endcase
    end else if (accept) begin
      if (col_last) begin
        col_d   = '0;
        rem_x_d = '0;
        quo_x_d = '0;
        if (row_last) begin
          row_d   = '0;
          rem_y_d = '0;
          quo_y_d = '0;
          if (slice_last) begin
            slice_d = '0;
            rem_z_d = '0;
          end else begin
            slice_d = SLICE_W'(slice_q + 1'b1);
            rem_z_d = (rem_z_q == bm1) ? '0 : BIN_W'(rem_z_q + 1'b1);
          end
        end else begin
          row_d = POS_W'(row_q + 1'b1);
          if (rem_y_q == bm1) begin
            rem_y_d = '0;
            quo_y_d = POS_W'(quo_y_q + 1'b1);
          end else begin
            rem_y_d = BIN_W'(rem_y_q + 1'b1);
          end
        end
      end else begin
        col_d = POS_W'(col_q + 1'b1);
        if (run_end) begin
          rem_x_d = '0;
          quo_x_d = POS_W'(quo_x_q + 1'b1);
        end else begin
          rem_x_d = BIN_W'(rem_x_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      slice_q   <= '0;
      rem_x_q   <= '0;
      rem_y_q   <= '0;
      rem_z_q   <= '0;
      quo_x_q   <= '0;
      quo_y_q   <= '0;
      onx_q     <= '0;
      ony_q     <= '0;
      lim_x_q   <= '0;
      lim_y_q   <= '0;
      lim_z_q   <= '0;
      run_sum_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      slice_q <= slice_d;
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      rem_z_q <= rem_z_d;
      quo_x_q <= quo_x_d;
      quo_y_q <= quo_y_d;
      onx_q   <= onx_d;
      ony_q   <= ony_d;
      lim_x_q <= lim_x_d;
      lim_y_q <= lim_y_d;
      lim_z_q <= lim_z_d;
      if (accept && in_range) begin
        run_sum_q <= run_end ? '0 : run_total;
      end
    end
  end

  // ---------------------------------------------------------------- line memory stage

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      e1_q   <= 1'b0;
      wr_v_q <= 1'b0;
    end else begin
      v1_q   <= accept && in_range && run_end;
      e1_q   <= accept && in_range && run_end && emit;
      wr_v_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q      <= first_blk;
    l1_q      <= last_blk;
    addr1_q   <= rd_addr;
    run1_q    <= run_total;
    wr_addr_q <= addr1_q;
    wr_data_q <= blk_sum;
  end

  // the entry written last cycle was read before that write landed
  always_comb begin
    if (f1_q) begin
      base = '0;
    end else if (wr_v_q && (wr_addr_q == addr1_q)) begin
      base = wr_data_q;
    end else begin
      base = rdata_q;
    end
    blk_sum = base + SUM_W'(run1_q);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      line_mem[addr1_q] <= blk_sum;
    end
    rdata_q <= line_mem[rd_addr];
  end

  // ---------------------------------------------------------------- scaling

  assign rh   = recip_q[RECIP_W-1:RECIP_SPLIT];
  assign rl   = recip_q[RECIP_SPLIT-1:0];
  assign ph_d = sum2_q * $signed({1'b0, rh});
  assign pl_d = sum2_q * $signed({1'b0, rl});

  // floor of sum * recip / 2^24, saturated to the average range
  assign t_sum  = ph3_q + PH_W'(pl3_q >>> RECIP_SPLIT);
  assign q_full = t_sum >>> SH;
  assign q_fits = (q_full[PH_W-1:AVG_W-1] == '0) || (q_full[PH_W-1:AVG_W-1] == '1);

  always_comb begin
    if (q_fits) begin
      avg_d = q_full[AVG_W-1:0];
    end else if (q_full[PH_W-1]) begin
      avg_d = AVG_MIN;
    end else begin
      avg_d = AVG_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= e1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l2_q   <= l1_q;
    sum2_q <= blk_sum;
    l3_q   <= l2_q;
    ph3_q  <= ph_d;
    pl3_q  <= pl_d;
    l4_q   <= l3_q;
    avg4_q <= avg_d;
  end

  // ---------------------------------------------------------------- slice min / max

  assign new_min = (avg4_q < run_min_q) ? avg4_q : run_min_q;
  assign new_max = (avg4_q > run_max_q) ? avg4_q : run_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q <= AVG_MAX;
      run_max_q <= AVG_MIN;
    end else if (v4_q) begin
      run_min_q <= l4_q ? AVG_MAX : new_min;
      run_max_q <= l4_q ? AVG_MIN : new_max;
    end
  end

  // ---------------------------------------------------------------- result queue

  assign push                 = v4_q;
  assign pop                  = out_valid_o && !out_stall_i;
  assign push_entry.average   = avg4_q;
  assign push_entry.slice_end = l4_q;
  assign push_entry.slice_min = new_min;
  assign push_entry.slice_max = new_max;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
      end
      count_q <= CNT_W'(count_q + CNT_W'(push) - CNT_W'(pop));
    end
  end

  // keep room for every average already in the pipeline
  assign inflight   = CNT_W'(e1_q) + CNT_W'(v2_q) + CNT_W'(v3_q) + CNT_W'(v4_q);
  assign in_stall_o = busy || ((count_q + inflight) >= CNT_W'(OUT_DEPTH));

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = (count_q != '0);
  assign average_o   = head.average;
  assign slice_end_o = head.slice_end;
  assign slice_min_o = head.slice_min;
  assign slice_max_o = head.slice_max;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for voxel_block_average_3d_core, driven one request at a time
// a built-in predictor tracks block sums and slice min/max; needs vba3d_pkg and the core
`timescale 1ns / 100ps

module tb_top;
  import vba3d_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 8;
  localparam int RAND_ITEMS      = 1400;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int UNITY_RECIP     = 1 << FRAC_BITS;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i    = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [AVG_W-1:0]       average_o;
  logic                          slice_end_o;
  logic signed [AVG_W-1:0]       slice_min_o;
  logic signed [AVG_W-1:0]       slice_max_o;

  voxel_block_average_3d_core DUT (.*);

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // voxels waiting to be offered and averages waiting to come out
  logic signed [SAMPLE_BITS-1:0] voxel_q[$];
  out_entry_t                    avg_expect_q[$];

  int send_idle_pct = 10;
  int recv_idle_pct = 48;
  bit hold_arm      = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int errors        = 0;

  // predictor copy of the registers and of the block state
  logic [BIN_W-1:0]        cfg_bin   = BIN_RST;
  logic [RECIP_W-1:0]      cfg_recip = RECIP_RST;
  logic [POS_W-1:0]        cfg_w     = WIDTH_RST;
  logic [POS_W-1:0]        cfg_h     = HEIGHT_RST;
  logic [SLICE_W-1:0]      cfg_d     = DEPTH_RST;
  int unsigned             col_q     = 0;
  int unsigned             row_q     = 0;
  int unsigned             slice_q   = 0;
  logic signed [63:0]      run_acc   = '0;
  logic signed [63:0]      line_sum [MAX_WIDTH_DEF];
  logic signed [AVG_W-1:0] run_lo    = AVG_MAX;
  logic signed [AVG_W-1:0] run_hi    = AVG_MIN;

  // floor(sum * recip / 2^24) in two partial products, saturated to 32 bits
  function automatic logic signed [AVG_W-1:0] scale_to_avg(input logic signed [63:0] s);
    logic signed [63:0] hi_part, lo_part, t, q;
    hi_part = $signed({51'b0, cfg_recip[RECIP_W-1:RECIP_SPLIT]});
    lo_part = $signed({52'b0, cfg_recip[RECIP_SPLIT-1:0]});
    t = s * hi_part + ((s * lo_part) >>> RECIP_SPLIT);
    q = t >>> (FRAC_BITS - RECIP_SPLIT);
    if (q < AVG_MIN) return AVG_MIN;
    if (q > AVG_MAX) return AVG_MAX;
    return q[AVG_W-1:0];
  endfunction

  function automatic bit block_avg_step(input logic signed [SAMPLE_BITS-1:0] smp,
                                        output out_entry_t res);
    int unsigned b, w, h, d, onx, ony, onz, ox, oy;
    logic signed [AVG_W-1:0] avg;
    bit fired;
    b = (cfg_bin == 0) ? 1 : ((cfg_bin > MAX_BIN_DEF) ? MAX_BIN_DEF : cfg_bin);
    w = (cfg_w == 0) ? 1 : ((cfg_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cfg_w);
    h = (cfg_h == 0) ? 1 : ((cfg_h > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cfg_h);
    d = (cfg_d == 0) ? 1 : cfg_d;
    onx = w / b;
    ony = h / b;
    onz = d / b;
    fired = 1'b0;
    res = '0;
    if (col_q < onx * b && row_q < ony * b && slice_q < onz * b) begin
      run_acc = run_acc + smp;
      if (col_q % b == b - 1) begin
        ox = (col_q / b) % MAX_WIDTH_DEF;
        oy = row_q / b;
        // first row of a block's first slice opens the line entry
        if (row_q % b == 0 && slice_q % b == 0) line_sum[ox] = run_acc;
        else line_sum[ox] = line_sum[ox] + run_acc;
        run_acc = '0;
        if (row_q % b == b - 1 && slice_q % b == b - 1) begin
          avg = scale_to_avg(line_sum[ox]);
          if (avg < run_lo) run_lo = avg;
          if (avg > run_hi) run_hi = avg;
          res.average   = avg;
          res.slice_end = (col_q / b == onx - 1) && (oy == ony - 1);
          res.slice_min = run_lo;
          res.slice_max = run_hi;
          if (res.slice_end) begin
            run_lo = AVG_MAX;
            run_hi = AVG_MIN;
          end
          fired = 1'b1;
        end
      end
    end
    if (col_q + 1 >= w) begin
      col_q = 0;
      if (row_q + 1 >= h) begin
        row_q = 0;
        if (slice_q + 1 >= d) slice_q = 0;
        else slice_q++;
      end else begin
        row_q++;
      end
    end else begin
      col_q++;
    end
    return fired;
  endfunction

  // sender: offers the next voxel once the current request is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (voxel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        sample_i   <= voxel_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_arm && out_valid_o) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_arm    <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    out_entry_t exp_e, got_e;
    bit in_acc, out_acc;
    if (rst_ni) begin
      in_acc  = in_valid_i && !in_stall_o;
      out_acc = out_valid_o && !out_stall_i;
      quiet_cycles <= (in_acc || out_acc) ? 0 : quiet_cycles + 1;
      if (in_acc && block_avg_step(sample_i, exp_e)) avg_expect_q.push_back(exp_e);
      if (out_acc) begin
        got_e = {average_o, slice_end_o, slice_min_o, slice_max_o};
        if (avg_expect_q.size() == 0) begin
          errors++;
          $display("%0t: average request with none expected: avg %0d end %0b min %0d max %0d",
                   $time, average_o, slice_end_o, slice_min_o, slice_max_o);
        end else begin
          exp_e = avg_expect_q.pop_front();
          if (got_e !== exp_e) begin
            errors++;
            $display("%0t: expected avg %0d end %0b min %0d max %0d", $time, exp_e.average,
                     exp_e.slice_end, exp_e.slice_min, exp_e.slice_max);
            $display("%0t: actual   avg %0d end %0b min %0d max %0d", $time, got_e.average,
                     got_e.slice_end, got_e.slice_min, got_e.slice_max);
          end
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_BIN_FACTOR: cfg_bin   = val[BIN_W-1:0];
      CFG_RECIP_CUBE: cfg_recip = val[RECIP_W-1:0];
      CFG_VOL_WIDTH:  cfg_w     = val[POS_W-1:0];
      CFG_VOL_HEIGHT: cfg_h     = val[POS_W-1:0];
      CFG_VOL_DEPTH:  cfg_d     = val[SLICE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_volume(input int unsigned bin, recip, w, h, d);
    write_reg(CFG_BIN_FACTOR, bin);
    write_reg(CFG_RECIP_CUBE, recip);
    write_reg(CFG_VOL_WIDTH, w);
    write_reg(CFG_VOL_HEIGHT, h);
    write_reg(CFG_VOL_DEPTH, d);
  endtask

  // nothing pending, nothing owed, and the pipe given time to empty
  task automatic settle();
    @(negedge clk_i);
    while (voxel_q.size() != 0 || in_valid_i || avg_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] gen_voxel();
    case ($urandom_range(9))
      0: return AVG_MAX;
      1: return AVG_MIN;
      2, 3, 4: return int'($urandom_range(2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_voxels(input int n);
    @(negedge clk_i);
    repeat (n) voxel_q.push_back(gen_voxel());
  endtask

  // a volume of 1x1x1 wraps every position on the next voxel, so a new
  // bin factor always starts on a fresh line of block sums
  task automatic align_volume();
    if (col_q != 0 || row_q != 0 || slice_q != 0) begin
      write_reg(CFG_VOL_WIDTH, 1);
      write_reg(CFG_VOL_HEIGHT, 1);
      write_reg(CFG_VOL_DEPTH, 1);
      queue_voxels(1);
      settle();
    end
  endtask

  function automatic int unsigned size_code(input int unsigned eff);
    return (eff == 1 && $urandom_range(1) == 1) ? 0 : eff;
  endfunction

  initial begin : watchdog
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase, small_items, n, eb, raw_bin, w, h, d, vol, recip, sel;
    phase = 0;
    small_items = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: bin of one, so each voxel is its own average
    @(negedge clk_i);
    voxel_q.push_back(AVG_MAX);
    voxel_q.push_back(AVG_MIN);
    voxel_q.push_back(32'sd0);
    voxel_q.push_back(-32'sd1);
    voxel_q.push_back(32'sd1);
    settle();
    // shrink the volume under a column position already past the new width
    write_reg(CFG_VOL_WIDTH, 0);
    write_reg(CFG_VOL_HEIGHT, 2);
    write_reg(CFG_VOL_DEPTH, 0);
    queue_voxels(4);
    settle();
    // largest reciprocal, about twice 1/B^3, saturates both ways
    write_reg(CFG_RECIP_CUBE, (1 << RECIP_W) - 1);
    @(negedge clk_i);
    voxel_q.push_back(AVG_MAX);
    voxel_q.push_back(AVG_MIN);
    voxel_q.push_back(32'sh4000_0000);
    voxel_q.push_back(32'shC000_0000);
    settle();
    // smallest reciprocal: -1 floors to -1, the extremes scale down to -128 and 127
    write_reg(CFG_RECIP_CUBE, 1);
    @(negedge clk_i);
    voxel_q.push_back(AVG_MIN);
    voxel_q.push_back(-32'sd1);
    voxel_q.push_back(AVG_MAX);
    settle();

    while (small_items < RAND_ITEMS || phase < 6) begin
      if (small_items < RAND_ITEMS / 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 48;
      end else if (small_items < 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      align_volume();
      sel = $urandom_range(99);
      if (phase == 2) begin
        // one full-width row at bin one, receiver held off part way
        set_volume(1, UNITY_RECIP, (1 << POS_W) - 1, 1, 1);
        hold_arm = 1'b1;
        queue_voxels(MAX_WIDTH_DEF);
      end else if (phase == 5) begin
        // largest bin, one trailing column dropped
        set_volume(MAX_BIN_DEF, UNITY_RECIP / (MAX_BIN_DEF ** 3),
                   MAX_BIN_DEF + 1, MAX_BIN_DEF, MAX_BIN_DEF);
        queue_voxels((MAX_BIN_DEF + 1) * MAX_BIN_DEF * MAX_BIN_DEF);
      end else if (sel < 8) begin
        // tall volumes, only the first rows are reached
        w = $urandom_range(1, 6);
        h = $urandom_range(1) ? MAX_WIDTH_DEF : $urandom_range(MAX_WIDTH_DEF + 1, 8191);
        set_volume($urandom_range(1), UNITY_RECIP, w, h, 65535);
        n = $urandom_range(40, 200);
        queue_voxels(n);
        small_items += n;
      end else begin
        sel = $urandom_range(99);
        if (sel < 8) begin
          raw_bin = 0;
          eb = 1;
        end else if (sel < 14) begin
          raw_bin = $urandom_range(MAX_BIN_DEF + 1, 31);
          eb = MAX_BIN_DEF;
        end else begin
          eb = $urandom_range(1, 4);
          raw_bin = eb;
        end
        if (eb == MAX_BIN_DEF) begin
          // block larger than the volume, never completes
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 6);
          d = $urandom_range(1, 6);
        end else begin
          do begin
            w = eb * $urandom_range(1, 4) + $urandom_range(0, eb - 1);
            h = eb * $urandom_range(1, 3) + $urandom_range(0, eb - 1);
            d = eb * $urandom_range(1, 2) + $urandom_range(0, eb - 1);
          end while (w * h * d > 400);
          if (eb > 1 && $urandom_range(19) == 0) d = $urandom_range(1, eb - 1);
        end
        sel = $urandom_range(9);
        if (sel == 0) recip = 1;
        else if (sel == 1) recip = (1 << RECIP_W) - 1;
        else if (sel == 2) recip = $urandom_range(1, (1 << RECIP_W) - 1);
        else recip = UNITY_RECIP / (eb * eb * eb);
        set_volume(raw_bin, recip, size_code(w), size_code(h), size_code(d));
        vol = w * h * d;
        n = ($urandom_range(3) == 0) ? $urandom_range(1, vol) : vol * $urandom_range(1, 2);
        queue_voxels(n);
        small_items += n;
      end
      settle();
      phase++;
    end

    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
